@@ design/spio_pkg.sv @@
// shared types and constants of the single-point information object parser
package spio_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned ALEN_W  = 2;

  // address length after reset, in bytes
  localparam logic [ALEN_W-1:0] ALEN_RESET = 2'd2;

  // positions of the quality flags inside the quality byte
  localparam int unsigned SPI_BIT = 0;
  localparam int unsigned BL_BIT  = 4;
  localparam int unsigned SB_BIT  = 5;
  localparam int unsigned NT_BIT  = 6;
  localparam int unsigned IV_BIT  = 7;

  // byte position of the address byte being collected
  typedef enum logic [ALEN_W-1:0] {
    ABYTE_LOW  = 2'd0,
    ABYTE_MID  = 2'd1,
    ABYTE_HIGH = 2'd2,
    ABYTE_OVER = 2'd3
  } abyte_t;

  // one body byte as taken from the input channel
  typedef struct packed {
    logic [DATA_W-1:0]  data_byte;
    logic               first_byte;
    logic               sequence_mode;
    logic [COUNT_W-1:0] object_count;
  } in_item_t;

  // one decoded information object
  typedef struct packed {
    logic [ADDR_W-1:0] object_address;
    logic [DATA_W-1:0] quality_byte;
    logic              point_state;
    logic              blocked;
    logic              substituted;
    logic              not_topical;
    logic              invalid;
    logic              last_object;
  } result_t;

endpackage

@@ design/spio_in_if.sv @@
// input channel of the parser: one body byte per request
interface spio_in_if;
  import spio_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_byte;
  logic               first_byte;
  logic               sequence_mode;
  logic [COUNT_W-1:0] object_count;

  modport source (
    output valid, data_byte, first_byte, sequence_mode, object_count,
    input  ready
  );

  modport sink (
    input  valid, data_byte, first_byte, sequence_mode, object_count,
    output ready
  );
endinterface

@@ design/spio_out_if.sv @@
// result channel of the parser: one information object per request
interface spio_out_if;
  import spio_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] object_address;
  logic [DATA_W-1:0] quality_byte;
  logic              point_state;
  logic              blocked;
  logic              substituted;
  logic              not_topical;
  logic              invalid;
  logic              last_object;

  modport source (
    output valid, object_address, quality_byte, point_state, blocked,
           substituted, not_topical, invalid, last_object,
    input  ready
  );

  modport sink (
    input  valid, object_address, quality_byte, point_state, blocked,
           substituted, not_topical, invalid, last_object,
    output ready
  );
endinterface

@@ design/spio_in_stage.sv @@
// input register: holds one body byte until the parser consumes it
module spio_in_stage
  import spio_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  spio_in_if.sink  in_ch,
  input  logic     item_take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  // accept whenever the register is empty or drains this cycle
  assign in_ch.ready = !valid_r || item_take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte     <= in_ch.data_byte;
      item_r.first_byte    <= in_ch.first_byte;
      item_r.sequence_mode <= in_ch.sequence_mode;
      item_r.object_count  <= in_ch.object_count;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ design/spio_parse.sv @@
// parser state and per-byte decode of the information object body
module spio_parse
  import spio_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ALEN_W-1:0] address_length,
  input  logic              item_valid,
  input  in_item_t          item,
  input  logic              out_free,
  output logic              item_take,
  output logic              res_valid,
  output result_t           res
);

  logic [ADDR_W-1:0]  acc_r, acc_nxt;
  abyte_t             cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               seq_r, seq_nxt;
  logic               expq_r, expq_nxt;

  // values after a possible restart on the first byte
  logic [ADDR_W-1:0]  acc_s;
  abyte_t             cnt_s;
  logic [COUNT_W-1:0] rem_s;
  logic [COUNT_W-1:0] idx_s;
  logic               seq_s;
  logic               expq_s;

  logic [ALEN_W-1:0]  len_eff;
  logic [ALEN_W-1:0]  cnt_inc;
  logic [ADDR_W-1:0]  acc_or;
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] rem_dec;

  // a byte is consumed when the result register can take its result
  assign item_take = item_valid && out_free;

  // restart on the first body byte
  always_comb begin
    if (item.first_byte) begin
      seq_s  = item.sequence_mode;
      rem_s  = item.object_count;
      idx_s  = '0;
      acc_s  = '0;
      cnt_s  = ABYTE_LOW;
      expq_s = 1'b0;
    end else begin
      seq_s  = seq_r;
      rem_s  = rem_r;
      idx_s  = idx_r;
      acc_s  = acc_r;
      cnt_s  = cnt_r;
      expq_s = expq_r;
    end
  end

  // little-endian address assembly
  always_comb begin
    unique case (cnt_s)
      ABYTE_LOW:  acc_or = acc_s | {16'd0, item.data_byte};
      ABYTE_MID:  acc_or = acc_s | {8'd0, item.data_byte, 8'd0};
      ABYTE_HIGH: acc_or = acc_s | {item.data_byte, 16'd0};
      default:    acc_or = acc_s;
    endcase
  end

  assign len_eff = (address_length == '0) ? ALEN_W'(1) : address_length;
  assign cnt_inc = ALEN_W'(cnt_s) + ALEN_W'(1);
  assign rem_dec = rem_s - COUNT_W'(1);
  assign addr    = seq_s ? (acc_s + {{(ADDR_W-COUNT_W){1'b0}}, idx_s}) : acc_s;

  // next state and result
  always_comb begin
    seq_nxt   = seq_s;
    rem_nxt   = rem_s;
    idx_nxt   = idx_s;
    acc_nxt   = acc_s;
    cnt_nxt   = cnt_s;
    expq_nxt  = expq_s;
    res_valid = 1'b0;
    if (rem_s == '0) begin
      res_valid = 1'b0;
    end else if (!expq_s) begin
      acc_nxt = acc_or;
      if (cnt_inc >= len_eff) begin
        cnt_nxt  = ABYTE_LOW;
        expq_nxt = 1'b1;
      end else begin
        cnt_nxt = abyte_t'(cnt_inc);
      end
    end else begin
      res_valid = 1'b1;
      rem_nxt   = rem_dec;
      idx_nxt   = idx_s + COUNT_W'(1);
      if (!seq_s) begin
        acc_nxt  = '0;
        expq_nxt = 1'b0;
      end
    end
  end

  // decoded result: object address, quality byte and flags, last-object mark
  always_comb begin
    res.object_address = addr;
    res.quality_byte   = item.data_byte;
    res.point_state    = item.data_byte[SPI_BIT];
    res.blocked        = item.data_byte[BL_BIT];
    res.substituted    = item.data_byte[SB_BIT];
    res.not_topical    = item.data_byte[NT_BIT];
    res.invalid        = item.data_byte[IV_BIT];
    res.last_object    = (rem_dec == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= ABYTE_LOW;
      rem_r  <= '0;
      idx_r  <= '0;
      seq_r  <= 1'b0;
      expq_r <= 1'b0;
    end else if (item_take) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      idx_r  <= idx_nxt;
      seq_r  <= seq_nxt;
      expq_r <= expq_nxt;
    end
  end

  // the byte position never rests past the top address byte
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != ABYTE_OVER)
    else $error("address byte position out of range");

  // each object of a running body uses up one from the count
  a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && res_valid && !item.first_byte
    |=> rem_r == COUNT_W'($past(rem_r) - COUNT_W'(1)))
    else $error("object count not decremented");

  // after the last object nothing further is left
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && res_valid && res.last_object |=> rem_r == '0)
    else $error("objects left after last object");

  // a separate-address object restarts address collection
  a_sep_restart: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && res_valid && !seq_s |=> !expq_r && acc_r == '0)
    else $error("address collection not restarted");

endmodule

@@ design/spio_out_stage.sv @@
// result register: holds one decoded object until the receiver takes it
module spio_out_stage
  import spio_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_load,
  input  result_t  res,
  output logic     out_free,
  spio_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // free when empty or emptied this cycle
  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  // drive the result channel
  assign out_ch.valid          = valid_r;
  assign out_ch.object_address = res_r.object_address;
  assign out_ch.quality_byte   = res_r.quality_byte;
  assign out_ch.point_state    = res_r.point_state;
  assign out_ch.blocked        = res_r.blocked;
  assign out_ch.substituted    = res_r.substituted;
  assign out_ch.not_topical    = res_r.not_topical;
  assign out_ch.invalid        = res_r.invalid;
  assign out_ch.last_object    = res_r.last_object;

endmodule

@@ design/single_point_info_object_parser_top.sv @@
// top level of the single-point information object parser
//
// in_ch carries the information object body one byte per request; the
// request flagged first_byte restarts the parser and samples the sequence
// flag and the object count. out_ch carries one request per quality byte:
// object address, raw quality byte, decoded flags and a last-object mark.
// Address bytes, bytes of an empty body and bytes after the last object
// give no output request. cfg_we/cfg_wdata set the address length (1..3
// bytes, 0 acts as 1); write it only while the parser is idle.
// A byte accepted into the input register is decoded and, once the result
// register is free, loaded there to drive out_ch. Throughput: one byte per
// cycle unless out_ch stalls, set by the input -> decode -> result path.
// Reset (rst_n low, synchronous) empties both registers, clears the parser
// state and sets the address length to 2. While out_ch is stalled the held
// result stays put; one more byte may wait in the input register, and
// in_ch.ready drops once both are full.
module single_point_info_object_parser_top
  import spio_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  spio_in_if.sink           in_ch,
  spio_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [ALEN_W-1:0] cfg_wdata
);

  logic [ALEN_W-1:0] alen_r;
  logic              item_valid;
  logic              item_take;
  in_item_t          item;
  logic              out_free;
  logic              res_valid;
  result_t           res;

  // address length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= ALEN_RESET;
    end else if (cfg_we) begin
      alen_r <= cfg_wdata;
    end
  end

  spio_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  spio_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .address_length (alen_r),
    .item_valid     (item_valid),
    .item           (item),
    .out_free       (out_free),
    .item_take      (item_take),
    .res_valid      (res_valid),
    .res            (res)
  );

  spio_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (item_take && res_valid),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
